### rtl/rrts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_SLEEP  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_UNUSED   = 2'd0,
    ST_READY    = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_SLEEPING = 2'd3
  } slot_st_t;

  typedef struct packed {
    slot_st_t    st;
    logic [31:0] id;
    logic [63:0] wake;
    logic [31:0] runs;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CREATE,
    OP_RD,
    OP_LOC,
    OP_WAKE,
    OP_RR,
    OP_CUR_RD,
    OP_CUR
  } op_t;

  typedef struct packed {
    logic idle;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    logic rsp_done;
    req_t req_type;
    logic count_zero;
    logic idx_end;
    logic match;
    logic runnable;
    logic step_full;
  } dp_stat_t;

endpackage
`default_nettype wire

### rtl/rrts_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rrts_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] task_id;
  logic [63:0] wake_time;
  logic [63:0] now_time;

  modport source (output valid, req_type, task_id, wake_time, now_time, input ready);
  modport sink (input valid, req_type, task_id, wake_time, now_time, output ready);
endinterface

interface rrts_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [31:0] new_task_id;
  logic [31:0] current_task;
  logic [6:0]  task_count;
  logic [1:0]  found_state;
  logic [31:0] found_run_ticks;
  logic [63:0] found_wake_tick;

  modport source (output valid, ok, new_task_id, current_task, task_count, found_state,
                  found_run_ticks, found_wake_tick, input ready);
  modport sink (input valid, ok, new_task_id, current_task, task_count, found_state,
                found_run_ticks, found_wake_tick, output ready);
endinterface
`default_nettype wire

### rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler with sleep.
// Channels: req (valid/ready) carries req_type, task_id, wake_time, now_time;
// rsp (valid/ready) returns one result transaction per request.
// One request is in flight at a time; req.ready is high only when idle.
// All slot fields live in one single-port-read slot memory, visited one slot
// at a time, each in a read state and then an evaluate/write-back state:
//   create: no slot scan; the new slot is written directly
//   sleep/lookup: slots are scanned from slot 0 up to the match or the last task
//   tick: a wake pass over all tasks created, then the round-robin cursor
//         steps through at most SLOTS slots (64) to the next runnable task
// After rsp is taken the scheduler returns to idle before the next request.
// Slot occupancy follows the created count, so no clearing pass is needed
// after reset: a synchronous rst empties the table, sets the next id to 1
// and the cursor to 0, and drops any pending result.
// If rsp.ready is low the result holds and no new request is taken.
`timescale 1ns / 1ps
`default_nettype none
module round_robin_task_scheduler (
  input  wire logic  clk,
  input  wire logic  rst,
  rrts_req_if.sink   req,
  rrts_rsp_if.source rsp
);
  rrts_pkg::cmd_t     cmd;
  rrts_pkg::dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  rrts_datapath u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );
endmodule
`default_nettype wire

### rtl/rrts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/rrts_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rrts_datapath (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire rrts_pkg::cmd_t cmd,
  output rrts_pkg::dp_stat_t stat,
  rrts_req_if.sink        req,
  rrts_rsp_if.source      rsp
);
  localparam int IW = rrts_pkg::IDX_W;
  localparam int CW = rrts_pkg::CNT_W;

  rrts_pkg::req_t   req_type;
  logic [31:0]      id_r;
  logic [63:0]      wake_r;
  logic [63:0]      now_r;
  logic [IW-1:0]    idx;
  logic [CW-1:0]    step;
  logic [IW-1:0]    cursor;
  logic [CW-1:0]    count;
  logic [31:0]      next_id;
  logic             ok;
  logic [31:0]      new_id;
  logic [31:0]      cur;
  logic [1:0]       f_state;
  logic [31:0]      f_runs;
  logic [63:0]      f_wake;
  logic             out_valid;

  rrts_pkg::entry_t rd;
  rrts_pkg::entry_t wdata;
  logic [rrts_pkg::ENTRY_W-1:0] rdata;
  logic             we;
  logic [IW-1:0]    waddr;
  logic [IW-1:0]    raddr;
  logic             full;
  logic             idx_end;
  logic             in_use;
  logic             match;
  logic             runnable;
  logic [IW-1:0]    idx_inc;
  logic [IW-1:0]    cursor_inc;

  assign rd         = rrts_pkg::entry_t'(rdata);
  assign full       = (count == CW'(rrts_pkg::SLOTS));
  assign idx_end    = (CW'(idx) + CW'(1) == count);
  assign in_use     = (CW'(idx) < count);
  assign match      = (rd.id == id_r);
  assign runnable   = in_use && (rd.st == rrts_pkg::ST_READY || rd.st == rrts_pkg::ST_RUNNING);
  assign idx_inc    = (idx == IW'(rrts_pkg::SLOTS - 1)) ? '0 : idx + IW'(1);
  assign cursor_inc = (cursor == IW'(rrts_pkg::SLOTS - 1)) ? '0 : cursor + IW'(1);
  assign raddr      = (cmd.op == rrts_pkg::OP_CUR_RD) ? cursor : idx;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = rd;
    unique case (cmd.op)
      rrts_pkg::OP_CREATE: begin
        if (!full) begin
          we    = 1'b1;
          waddr = IW'(count);
          wdata = '{st: rrts_pkg::ST_READY, id: next_id, wake: '0, runs: '0};
        end
      end
      rrts_pkg::OP_LOC: begin
        if (match && req_type == rrts_pkg::REQ_SLEEP) begin
          we         = 1'b1;
          wdata.st   = rrts_pkg::ST_SLEEPING;
          wdata.wake = wake_r;
        end
      end
      rrts_pkg::OP_WAKE: begin
        if (rd.st == rrts_pkg::ST_SLEEPING && rd.wake <= now_r) begin
          we       = 1'b1;
          wdata.st = rrts_pkg::ST_READY;
        end
      end
      rrts_pkg::OP_RR: begin
        if (runnable) begin
          we         = 1'b1;
          wdata.st   = rrts_pkg::ST_RUNNING;
          wdata.runs = rd.runs + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  rrts_ram #(.WIDTH(rrts_pkg::ENTRY_W), .DEPTH(rrts_pkg::SLOTS)) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      count     <= '0;
      next_id   <= 32'd1;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        rrts_pkg::OP_LOAD: begin
          req_type <= rrts_pkg::req_t'(req.req_type);
          id_r     <= req.task_id;
          wake_r   <= req.wake_time;
          now_r    <= req.now_time;
          idx      <= '0;
          ok       <= (req.req_type == rrts_pkg::REQ_TICK);
          new_id   <= '0;
          f_state  <= '0;
          f_runs   <= '0;
          f_wake   <= '0;
        end
        rrts_pkg::OP_CREATE: begin
          if (!full) begin
            count   <= count + CW'(1);
            next_id <= next_id + 32'd1;
            ok      <= 1'b1;
            new_id  <= next_id;
          end
        end
        rrts_pkg::OP_LOC: begin
          if (match) begin
            ok <= 1'b1;
            if (req_type == rrts_pkg::REQ_LOOKUP) begin
              f_state <= rd.st;
              f_runs  <= rd.runs;
              f_wake  <= rd.wake;
            end
          end else begin
            idx <= idx_inc;
          end
        end
        rrts_pkg::OP_WAKE: begin
          if (idx_end) begin
            idx  <= cursor_inc;
            step <= CW'(1);
          end else begin
            idx <= idx_inc;
          end
        end
        rrts_pkg::OP_RR: begin
          if (runnable) begin
            cursor <= idx;
          end else begin
            idx  <= idx_inc;
            step <= step + CW'(1);
          end
        end
        rrts_pkg::OP_CUR: begin
          cur       <= (CW'(cursor) < count) ? rd.id : 32'd0;
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign req.ready           = cmd.idle;
  assign rsp.valid           = out_valid;
  assign rsp.ok              = ok;
  assign rsp.new_task_id     = new_id;
  assign rsp.current_task    = cur;
  assign rsp.task_count      = 7'(count);
  assign rsp.found_state     = f_state;
  assign rsp.found_run_ticks = f_runs;
  assign rsp.found_wake_tick = f_wake;

  assign stat.req_valid  = req.valid;
  assign stat.rsp_done   = out_valid && rsp.ready;
  assign stat.req_type   = req_type;
  assign stat.count_zero = (count == '0);
  assign stat.idx_end    = idx_end;
  assign stat.match      = match;
  assign stat.runnable   = runnable;
  assign stat.step_full  = (step == CW'(rrts_pkg::SLOTS));

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(rrts_pkg::SLOTS)) else $error("task count beyond table size");
  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count >= $past(count)) else $error("task count decreased");
  a_newid_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && new_id != 32'd0 |-> ok) else $error("new id without ok");
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    CW'(cursor) < CW'(rrts_pkg::SLOTS)) else $error("cursor out of range");
`endif
endmodule
`default_nettype wire

### rtl/rrts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rrts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire rrts_pkg::dp_stat_t stat,
  output rrts_pkg::cmd_t     cmd
);
  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_LOC_RD, S_LOC_EV, S_WAKE_RD, S_WAKE_EV,
    S_RR_RD, S_RR_EV, S_CUR_RD, S_CUR_EV, S_SEND
  } state_t;

  state_t state;

  always_comb begin
    cmd.idle = (state == S_IDLE);
    unique case (state)
      S_IDLE:    cmd.op = stat.req_valid ? rrts_pkg::OP_LOAD : rrts_pkg::OP_NONE;
      S_DISP:    cmd.op = (stat.req_type == rrts_pkg::REQ_CREATE) ? rrts_pkg::OP_CREATE
                                                                  : rrts_pkg::OP_NONE;
      S_LOC_RD,
      S_WAKE_RD,
      S_RR_RD:   cmd.op = rrts_pkg::OP_RD;
      S_LOC_EV:  cmd.op = rrts_pkg::OP_LOC;
      S_WAKE_EV: cmd.op = rrts_pkg::OP_WAKE;
      S_RR_EV:   cmd.op = rrts_pkg::OP_RR;
      S_CUR_RD:  cmd.op = rrts_pkg::OP_CUR_RD;
      S_CUR_EV:  cmd.op = rrts_pkg::OP_CUR;
      S_SEND:    cmd.op = rrts_pkg::OP_NONE;
      default:   cmd.op = rrts_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (stat.req_valid) state <= S_DISP;
        end
        S_DISP: begin
          unique case (stat.req_type)
            rrts_pkg::REQ_CREATE: state <= S_CUR_RD;
            rrts_pkg::REQ_TICK:   state <= stat.count_zero ? S_CUR_RD : S_WAKE_RD;
            default:              state <= stat.count_zero ? S_CUR_RD : S_LOC_RD;
          endcase
        end
        S_LOC_RD:  state <= S_LOC_EV;
        S_LOC_EV: begin
          priority if (stat.match || stat.idx_end) state <= S_CUR_RD;
          else state <= S_LOC_RD;
        end
        S_WAKE_RD: state <= S_WAKE_EV;
        S_WAKE_EV: state <= stat.idx_end ? S_RR_RD : S_WAKE_RD;
        S_RR_RD:   state <= S_RR_EV;
        S_RR_EV: begin
          priority if (stat.runnable || stat.step_full) state <= S_CUR_RD;
          else state <= S_RR_RD;
        end
        S_CUR_RD:  state <= S_CUR_EV;
        S_CUR_EV:  state <= S_SEND;
        S_SEND: begin
          if (stat.rsp_done) state <= S_IDLE;
        end
        default:   state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
